// ===== hdl/igd_pkg.sv =====
// types and constants shared by the insect gate decision block
`timescale 1ns / 1ps
`default_nettype none

package igd_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_CAUTION = 2'd1,
        MODE_OPEN    = 2'd2,
        MODE_ALERT   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CLS_NONE       = 2'd0,
        CLS_POLLINATOR = 2'd1,
        CLS_PEST       = 2'd2,
        CLS_UNCERTAIN  = 2'd3
    } t_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLLINATOR_THR  = 3'd0,
        CFG_PEST_ALERT_THR  = 3'd1,
        CFG_PEST_CAUTION_THR = 3'd2,
        CFG_CAUTION_MIN_MS  = 3'd3,
        CFG_OPEN_MS         = 3'd4,
        CFG_ALERT_MS        = 3'd5,
        CFG_POLLINATION_MS  = 3'd6
    } t_cfg_idx;

    localparam logic [7:0]  RST_POLLINATOR_THR   = 8'd128;
    localparam logic [7:0]  RST_PEST_ALERT_THR   = 8'd153;
    localparam logic [7:0]  RST_PEST_CAUTION_THR = 8'd128;
    localparam logic [15:0] RST_CAUTION_MIN_MS   = 16'd3000;
    localparam logic [15:0] RST_OPEN_MS          = 16'd8000;
    localparam logic [15:0] RST_ALERT_MS         = 16'd5000;
    localparam logic [15:0] RST_POLLINATION_MS   = 16'd1500;

    typedef struct packed {
        logic [7:0]  pollinator_threshold;
        logic [7:0]  pest_alert_threshold;
        logic [7:0]  pest_caution_threshold;
        logic [15:0] caution_min_ms;
        logic [15:0] open_ms;
        logic [15:0] alert_ms;
        logic [15:0] pollination_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  insect_class;
        logic [7:0]  confidence;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        t_mode       mode;
        logic        mode_changed;
        logic        open_access;
        logic        close_access;
        logic        red_led;
        logic [15:0] pollinate_request_ms;
        logic        repel;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/igd_cfg_regs.sv =====
// configuration register file for the insect gate decision block
`timescale 1ns / 1ps
`default_nettype none

module igd_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_wr_en,
    input  wire logic [igd_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [15:0]                  i_wr_data,
    output igd_pkg::t_cfg                     o_cfg
);
    import igd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pollinator_threshold   <= RST_POLLINATOR_THR;
            r_cfg.pest_alert_threshold   <= RST_PEST_ALERT_THR;
            r_cfg.pest_caution_threshold <= RST_PEST_CAUTION_THR;
            r_cfg.caution_min_ms         <= RST_CAUTION_MIN_MS;
            r_cfg.open_ms                <= RST_OPEN_MS;
            r_cfg.alert_ms               <= RST_ALERT_MS;
            r_cfg.pollination_ms         <= RST_POLLINATION_MS;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_POLLINATOR_THR:   r_cfg.pollinator_threshold   <= i_wr_data[7:0];
                CFG_PEST_ALERT_THR:   r_cfg.pest_alert_threshold   <= i_wr_data[7:0];
                CFG_PEST_CAUTION_THR: r_cfg.pest_caution_threshold <= i_wr_data[7:0];
                CFG_CAUTION_MIN_MS:   r_cfg.caution_min_ms         <= i_wr_data;
                CFG_OPEN_MS:          r_cfg.open_ms                <= i_wr_data;
                CFG_ALERT_MS:         r_cfg.alert_ms               <= i_wr_data;
                CFG_POLLINATION_MS:   r_cfg.pollination_ms         <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/igd_mode_logic.sv =====
// next-mode decision and result formation for one detection
`timescale 1ns / 1ps
`default_nettype none

module igd_mode_logic (
    input  wire igd_pkg::t_mode i_mode,
    input  wire logic [31:0]    i_last_change_ms,
    input  wire logic           i_led,
    input  wire igd_pkg::t_item i_item,
    input  wire igd_pkg::t_cfg  i_cfg,
    output igd_pkg::t_mode      o_next_mode,
    output logic                o_changed,
    output logic                o_next_led,
    output igd_pkg::t_result    o_result
);
    import igd_pkg::*;

    logic [31:0] elapsed;
    logic        is_poll_open;
    logic        is_pest_alert;
    logic        is_pest_caution;
    t_mode       next_mode;
    logic        changed;
    logic        next_led;

    assign elapsed         = i_item.now_ms - i_last_change_ms;
    assign is_poll_open    = (i_item.insect_class == CLS_POLLINATOR)
                             && (i_item.confidence > i_cfg.pollinator_threshold);
    assign is_pest_alert   = (i_item.insect_class == CLS_PEST)
                             && (i_item.confidence > i_cfg.pest_alert_threshold);
    assign is_pest_caution = (i_item.insect_class == CLS_PEST)
                             && (i_item.confidence > i_cfg.pest_caution_threshold);

    always_comb begin
        next_mode = i_mode;
        case (i_mode)
            MODE_IDLE: begin
                if (is_poll_open) begin
                    next_mode = MODE_OPEN;
                end else if (is_pest_alert) begin
                    next_mode = MODE_ALERT;
                end else if (i_item.insect_class == CLS_UNCERTAIN) begin
                    next_mode = MODE_CAUTION;
                end
            end
            MODE_CAUTION: begin
                if (is_pest_caution) begin
                    next_mode = MODE_ALERT;
                end else if (is_poll_open) begin
                    next_mode = MODE_OPEN;
                end else if ((elapsed > {16'd0, i_cfg.caution_min_ms})
                             && (i_item.insect_class == CLS_NONE)) begin
                    next_mode = MODE_IDLE;
                end
            end
            MODE_OPEN: begin
                if (is_pest_alert) begin
                    next_mode = MODE_ALERT;
                end else if (elapsed > {16'd0, i_cfg.open_ms}) begin
                    next_mode = MODE_IDLE;
                end
            end
            MODE_ALERT: begin
                if (elapsed > {16'd0, i_cfg.alert_ms}) begin
                    next_mode = (i_item.insect_class == CLS_NONE) ? MODE_IDLE : MODE_CAUTION;
                end
            end
            default: next_mode = i_mode;
        endcase
    end

    assign changed  = (next_mode != i_mode);
    assign next_led = changed ? (next_mode == MODE_ALERT) : i_led;

    always_comb begin
        o_result.mode                 = next_mode;
        o_result.mode_changed         = changed;
        o_result.open_access          = changed && (next_mode == MODE_OPEN);
        o_result.close_access         = changed && ((next_mode == MODE_IDLE)
                                                    || (next_mode == MODE_ALERT));
        o_result.red_led              = next_led;
        o_result.pollinate_request_ms = (changed && (next_mode == MODE_OPEN))
                                        ? i_cfg.pollination_ms : 16'd0;
        o_result.repel                = changed && (next_mode == MODE_ALERT);
    end

    assign o_next_mode = next_mode;
    assign o_changed   = changed;
    assign o_next_led  = next_led;

endmodule

`default_nettype wire

// ===== hdl/insect_gate_decision_fsm_unit.sv =====
// top level of the insect gate decision block
`timescale 1ns / 1ps
`default_nettype none

// insect gate decision unit: each request carries one classified detection
// (class, q0.8 confidence, millisecond timestamp) and yields exactly one
// result with the mode after the detection, a changed flag, access open and
// close pulses, the red led level, the pollination duration on opening and a
// repel pulse. requests pass an input register, the mode decision is one level
// of compares and a 32-bit wrapping subtraction, and the result lands in an
// output register. one request is taken every clock cycle when the result side
// keeps up; the result register loads when the staged request advances. the
// mode, last-change time and led level update in the same cycle the result
// register loads, so back-to-back requests see each other's effect with no gap.
// configuration registers are written through their own channel, always ready,
// and should only be written while no request is in flight.

module insect_gate_decision_fsm_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // detection request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_insect_class,
    input  wire logic [7:0]                    i_confidence,
    input  wire logic [31:0]                   i_now_ms,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_mode,
    output logic                               o_mode_changed,
    output logic                               o_open_access,
    output logic                               o_close_access,
    output logic                               o_red_led,
    output logic [15:0]                        o_pollinate_request_ms,
    output logic                               o_repel,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [igd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                   i_cfg_data
);
    import igd_pkg::*;

    // input register
    logic    r_in_valid;
    t_item   r_item;
    // controller state
    t_mode   r_mode;
    logic [31:0] r_last_change_ms;
    logic    r_led;
    // result register
    logic    r_out_valid;
    t_result r_res;

    t_cfg    cfg;
    t_mode   n_mode;
    logic    n_changed;
    logic    n_led;
    t_result n_res;
    logic    advance;
    logic    in_accept;

    assign o_cfg_ready = 1'b1;

    igd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    igd_mode_logic u_mode (
        .i_mode           (r_mode),
        .i_last_change_ms (r_last_change_ms),
        .i_led            (r_led),
        .i_item           (r_item),
        .i_cfg            (cfg),
        .o_next_mode      (n_mode),
        .o_changed        (n_changed),
        .o_next_led       (n_led),
        .o_result         (n_res)
    );

    // staged request moves on when the result slot is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.insect_class <= i_insect_class;
            r_item.confidence   <= i_confidence;
            r_item.now_ms       <= i_now_ms;
        end
    end

    // mode state commits together with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_IDLE;
            r_last_change_ms <= 32'd0;
            r_led            <= 1'b0;
        end else if (advance) begin
            r_mode <= n_mode;
            r_led  <= n_led;
            if (n_changed) begin
                r_last_change_ms <= r_item.now_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_mode                 = r_res.mode;
    assign o_mode_changed         = r_res.mode_changed;
    assign o_open_access          = r_res.open_access;
    assign o_close_access         = r_res.close_access;
    assign o_red_led              = r_res.red_led;
    assign o_pollinate_request_ms = r_res.pollinate_request_ms;
    assign o_repel                = r_res.repel;

endmodule

`default_nettype wire

// ===== tb/tb_insect_gate_decision_fsm_unit.sv =====
// self-checking testbench for the insect gate decision unit
`timescale 1ns / 1ps

module tb_insect_gate_decision_fsm_unit;
    import igd_pkg::*;

    // register index that the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    // mirrors the mode controller and queues the decision each request should produce
    class decision_tracker;
        t_cfg        cfg;
        t_mode       mode;
        logic [31:0] last_change_ms;
        logic        led;
        t_result     expected_decisions[$];
        int          mismatches;

        function new();
            cfg.pollinator_threshold   = RST_POLLINATOR_THR;
            cfg.pest_alert_threshold   = RST_PEST_ALERT_THR;
            cfg.pest_caution_threshold = RST_PEST_CAUTION_THR;
            cfg.caution_min_ms         = RST_CAUTION_MIN_MS;
            cfg.open_ms                = RST_OPEN_MS;
            cfg.alert_ms               = RST_ALERT_MS;
            cfg.pollination_ms         = RST_POLLINATION_MS;
            mode           = MODE_IDLE;
            last_change_ms = '0;
            led            = 1'b0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_POLLINATOR_THR:   cfg.pollinator_threshold   = data[7:0];
                CFG_PEST_ALERT_THR:   cfg.pest_alert_threshold   = data[7:0];
                CFG_PEST_CAUTION_THR: cfg.pest_caution_threshold = data[7:0];
                CFG_CAUTION_MIN_MS:   cfg.caution_min_ms         = data;
                CFG_OPEN_MS:          cfg.open_ms                = data;
                CFG_ALERT_MS:         cfg.alert_ms               = data;
                CFG_POLLINATION_MS:   cfg.pollination_ms         = data;
                default: ;
            endcase
        endfunction

        function void log_detection(t_item det);
            logic [31:0] elapsed;
            t_mode       nxt;
            t_result     res;
            logic        pollinator_hit;
            elapsed = det.now_ms - last_change_ms;
            nxt = mode;
            pollinator_hit = det.insect_class == CLS_POLLINATOR
                             && det.confidence > cfg.pollinator_threshold;
            case (mode)
                MODE_IDLE: begin
                    if (pollinator_hit)
                        nxt = MODE_OPEN;
                    else if (det.insect_class == CLS_PEST
                             && det.confidence > cfg.pest_alert_threshold)
                        nxt = MODE_ALERT;
                    else if (det.insect_class == CLS_UNCERTAIN)
                        nxt = MODE_CAUTION;
                end
                MODE_CAUTION: begin
                    if (det.insect_class == CLS_PEST
                        && det.confidence > cfg.pest_caution_threshold)
                        nxt = MODE_ALERT;
                    else if (pollinator_hit)
                        nxt = MODE_OPEN;
                    else if (elapsed > {16'd0, cfg.caution_min_ms}
                             && det.insect_class == CLS_NONE)
                        nxt = MODE_IDLE;
                end
                MODE_OPEN: begin
                    if (det.insect_class == CLS_PEST
                        && det.confidence > cfg.pest_alert_threshold)
                        nxt = MODE_ALERT;
                    else if (elapsed > {16'd0, cfg.open_ms})
                        nxt = MODE_IDLE;
                end
                default: begin
                    if (elapsed > {16'd0, cfg.alert_ms})
                        nxt = (det.insect_class == CLS_NONE) ? MODE_IDLE : MODE_CAUTION;
                end
            endcase
            res = '0;
            res.mode_changed = (nxt != mode);
            if (res.mode_changed) begin
                mode           = nxt;
                last_change_ms = det.now_ms;
                led            = (nxt == MODE_ALERT);
            end
            res.mode                 = mode;
            res.open_access          = res.mode_changed && mode == MODE_OPEN;
            res.close_access         = res.mode_changed
                                       && (mode == MODE_IDLE || mode == MODE_ALERT);
            res.red_led              = led;
            res.pollinate_request_ms = res.open_access ? cfg.pollination_ms : 16'd0;
            res.repel                = res.mode_changed && mode == MODE_ALERT;
            expected_decisions.push_back(res);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        endfunction

        function void check_decision(t_result got);
            t_result want;
            if (expected_decisions.size() == 0) begin
                flag("result with nothing pending", '0, got);
                return;
            end
            want = expected_decisions.pop_front();
            if (got.mode !== want.mode)
                flag("mode", want.mode, got.mode);
            if (got.mode_changed !== want.mode_changed)
                flag("mode_changed", want.mode_changed, got.mode_changed);
            if (got.open_access !== want.open_access)
                flag("open_access", want.open_access, got.open_access);
            if (got.close_access !== want.close_access)
                flag("close_access", want.close_access, got.close_access);
            if (got.red_led !== want.red_led)
                flag("red_led", want.red_led, got.red_led);
            if (got.pollinate_request_ms !== want.pollinate_request_ms)
                flag("pollinate_request_ms", want.pollinate_request_ms,
                     got.pollinate_request_ms);
            if (got.repel !== want.repel)
                flag("repel", want.repel, got.repel);
        endfunction

        function int outstanding();
            return expected_decisions.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_insect_class;
    logic [7:0]           i_confidence;
    logic [31:0]          i_now_ms;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_mode;
    logic                 o_mode_changed;
    logic                 o_open_access;
    logic                 o_close_access;
    logic                 o_red_led;
    logic [15:0]          o_pollinate_request_ms;
    logic                 o_repel;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    decision_tracker tracker;
    int              in_gap_max;
    int              out_stall_max;
    int              hold_cycles;
    logic [31:0]     now_track;

    insect_gate_decision_fsm_unit dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_insect_class         (i_insect_class),
        .i_confidence           (i_confidence),
        .i_now_ms               (i_now_ms),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_mode                 (o_mode),
        .o_mode_changed         (o_mode_changed),
        .o_open_access          (o_open_access),
        .o_close_access         (o_close_access),
        .o_red_led              (o_red_led),
        .o_pollinate_request_ms (o_pollinate_request_ms),
        .o_repel                (o_repel),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // every task starts and ends just after a falling edge; inputs only move there
    task automatic send_detection(input t_class cls, input logic [7:0] conf,
                                  input logic [31:0] stamp);
        t_item det;
        int    gap;
        det.insect_class = cls;
        det.confidence   = conf;
        det.now_ms       = stamp;
        i_in_valid       = 1'b1;
        i_insect_class   = cls;
        i_confidence     = conf;
        i_now_ms         = stamp;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        tracker.log_detection(det);
        now_track = stamp;
        @(negedge i_clk);
        // with no gap valid simply stays high into the next request
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_random_detection();
        logic [31:0] stamp;
        logic [15:0] span;
        logic [7:0]  thr;
        logic [7:0]  conf;
        // timeout and threshold that the boundary cases aim at
        case ($urandom_range(0, 2))
            0:       span = tracker.cfg.caution_min_ms;
            1:       span = tracker.cfg.open_ms;
            default: span = tracker.cfg.alert_ms;
        endcase
        case ($urandom_range(0, 2))
            0:       thr = tracker.cfg.pollinator_threshold;
            1:       thr = tracker.cfg.pest_alert_threshold;
            default: thr = tracker.cfg.pest_caution_threshold;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: stamp = now_track + $urandom_range(0, 300);
            // just below, at and just above a timeout since the last mode change
            4, 5, 6:    stamp = tracker.last_change_ms + {16'd0, span}
                                + $urandom_range(0, 2) - 1;
            7, 8:       stamp = now_track + $urandom_range(0, 70000);
            // jump anywhere, including backwards across the wrap
            default:    stamp = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2: conf = 8'($urandom_range(0, 255));
            3, 4, 5: conf = thr + 8'($urandom_range(0, 2)) - 8'd1;
            6:       conf = 8'd0;
            default: conf = 8'hFF;
        endcase
        send_detection(t_class'($urandom_range(0, 3)), conf, stamp);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] pollinator_thr, input logic [15:0] pest_thr,
                                  input logic [15:0] caution_thr, input logic [15:0] caution_ms,
                                  input logic [15:0] open_span, input logic [15:0] alert_span,
                                  input logic [15:0] pollination);
        write_reg(CFG_POLLINATOR_THR, pollinator_thr);
        write_reg(CFG_PEST_ALERT_THR, pest_thr);
        write_reg(CFG_PEST_CAUTION_THR, caution_thr);
        write_reg(CFG_CAUTION_MIN_MS, caution_ms);
        write_reg(CFG_OPEN_MS, open_span);
        write_reg(CFG_ALERT_MS, alert_span);
        write_reg(CFG_POLLINATION_MS, pollination);
        // unused index, must leave every register alone
        write_reg(CFG_IDX_SPARE, 16'($urandom));
    endtask

    // stop offering requests and let every pending result drain
    task automatic settle();
        i_in_valid = 1'b0;
        while (tracker.outstanding() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // result side: random stalls, one long hold-off on request, checks every result
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready = 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, out_stall_max);
                if (stall > 0) begin
                    i_out_ready = 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            tracker.check_decision('{mode: t_mode'(o_mode),
                                     mode_changed: o_mode_changed,
                                     open_access: o_open_access,
                                     close_access: o_close_access,
                                     red_led: o_red_led,
                                     pollinate_request_ms: o_pollinate_request_ms,
                                     repel: o_repel});
        end
    end

    // main sequence
    initial begin
        int sel;
        tracker        = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_insect_class = '0;
        i_confidence   = '0;
        i_now_ms       = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        in_gap_max     = 3;
        out_stall_max  = 3;
        hold_cycles    = 0;
        now_track      = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // directed walk through every transition with reset settings
        send_detection(CLS_NONE, 8'd255, 32'd0);
        send_detection(CLS_POLLINATOR, 8'd128, 32'd5);          // equal to threshold, stays idle
        send_detection(CLS_POLLINATOR, 8'd129, 32'd10);         // idle to open
        send_detection(CLS_PEST, 8'd153, 32'd20);               // pest at threshold, stays open
        send_detection(CLS_UNCERTAIN, 8'd0, 32'd8010);          // open for exactly the timeout
        send_detection(CLS_NONE, 8'd0, 32'd8011);               // open times out to idle
        send_detection(CLS_PEST, 8'd154, 32'd8100);             // idle to alert
        send_detection(CLS_NONE, 8'd0, 32'd13100);              // alert timeout not yet passed
        send_detection(CLS_UNCERTAIN, 8'd77, 32'd13101);        // alert to caution
        send_detection(CLS_PEST, 8'd128, 32'd13200);            // pest at caution threshold
        send_detection(CLS_NONE, 8'd0, 32'd16101);              // caution for exactly the minimum
        send_detection(CLS_NONE, 8'd0, 32'd16102);              // caution to idle
        send_detection(CLS_UNCERTAIN, 8'd255, 32'd16200);       // idle to caution
        send_detection(CLS_POLLINATOR, 8'd255, 32'd16300);      // caution to open
        send_detection(CLS_PEST, 8'd255, 32'd16301);            // open to alert
        send_detection(CLS_POLLINATOR, 8'd255, 32'hFFFF_FFFF); // alert to caution near the wrap
        send_detection(CLS_PEST, 8'd129, 32'd0);                // caution to alert across the wrap
        send_detection(CLS_NONE, 8'd0, 32'd3);                  // short alert stays
        send_detection(CLS_NONE, 8'd0, 32'hFFFF_FF00);          // earlier stamp reads as long, to idle
        send_detection(CLS_PEST, 8'd153, 32'hFFFF_FF01);        // pest at alert threshold, stays idle
        send_detection(CLS_UNCERTAIN, 8'd0, 32'hAAAA_5555);
        send_detection(CLS_POLLINATOR, 8'd128, 32'h5555_AAAA);  // caution, long but class not none
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: apply_settings(16'(RST_POLLINATOR_THR), 16'(RST_PEST_ALERT_THR),
                                  16'(RST_PEST_CAUTION_THR), RST_CAUTION_MIN_MS,
                                  RST_OPEN_MS, RST_ALERT_MS, RST_POLLINATION_MS);
                1: apply_settings('0, '0, '0, '0, '0, '0, '0);
                2: apply_settings('1, '1, '1, '1, '1, '1, '1);
                // random thresholds with stray upper bits, short timeouts
                default: apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                        16'($urandom_range(0, 2500)),
                                        16'($urandom_range(0, 2500)),
                                        16'($urandom_range(0, 2500)), 16'($urandom));
            endcase
            for (int chunk = 0; chunk < 3; chunk++) begin
                sel           = (phase + chunk) % 4;
                in_gap_max    = (sel % 2 == 1) ? 19 : 0;
                out_stall_max = (sel >= 2) ? 19 : 0;
                if (phase == 0 && chunk == 1) begin
                    // result side blocks while requests keep coming back to back
                    in_gap_max  = 0;
                    hold_cycles = 150;
                end
                repeat (50) send_random_detection();
                settle();
            end
        end

        repeat (10) @(negedge i_clk);
        if (tracker.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/igd_pkg.sv
hdl/igd_cfg_regs.sv
hdl/igd_mode_logic.sv
hdl/insect_gate_decision_fsm_unit.sv
tb/tb_insect_gate_decision_fsm_unit.sv
